@@ hdl/lag_pkg.sv @@
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants for the life automaton generation block.
// ----------------------------------------------------------------------------
package lag_pkg;

  // Width of the board side register
  localparam int CFG_W = 11;

  // Smallest legal board side, border included
  localparam int MIN_SIDE = 3;

  // B3/S23 rule counts
  localparam int BIRTH_COUNT   = 3;
  localparam int SURVIVE_COUNT = 2;

  // Window layout: row k in bits 3k..3k+2, column 2 newest
  localparam int       WIN_W      = 9;
  localparam int       CENTRE_BIT = 4;
  localparam logic [WIN_W-1:0] SHIFT_MASK = 9'h0DB;
  localparam logic [WIN_W-1:0] NEIGH_MASK = 9'h1EF;

  // Item handed from the read stage to the rule unit
  typedef struct packed {
    logic adv;      // item leaves the read stage this cycle
    logic restart;  // board restart from a side write
    logic cell_in;  // incoming cell state
    logic up;       // line buffer: two rows up
    logic mid;      // line buffer: one row up
    logic prod;     // item carries a result
    logic last;     // final interior cell of the board
  } lag_step_t;

  // Rule unit result
  typedef struct packed {
    logic next_alive;
    logic changed_so_far;
  } lag_res_t;

endpackage

@@ hdl/lag_line_mem.sv @@
// ----------------------------------------------------------------------------
// lag_line_mem
// Line buffer memory: two 1-bit rows side by side, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module lag_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [1:0]               rd_data,   // bit0 upper row, bit1 middle row
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_data
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/lag_rule.sv @@
// ----------------------------------------------------------------------------
// lag_rule
// 3x3 neighborhood window, B3/S23 rule and the running change flag.
// ----------------------------------------------------------------------------
module lag_rule
  import lag_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  lag_step_t step,
  output lag_res_t  res
);

  logic [WIN_W-1:0] window_r, window_nxt;
  logic             any_r, any_nxt;
  logic [3:0]       score;
  logic             centre;
  logic             next_alive;

  function automatic logic [3:0] count8(input logic [WIN_W-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  // Shift in the new column
  always_comb begin
    window_nxt = ((window_r >> 1) & SHIFT_MASK)
               | {step.cell_in, 2'b00, step.mid, 2'b00, step.up, 2'b00};
  end

  // Rule on the updated window
  always_comb begin
    centre     = window_nxt[CENTRE_BIT];
    score      = count8(window_nxt & NEIGH_MASK);
    next_alive = (score == 4'(BIRTH_COUNT)) || (centre && score == 4'(SURVIVE_COUNT));
  end

  // Change flag, cleared after the board's final cell and on a restart
  always_comb begin
    any_nxt = any_r;
    if (step.restart) begin
      any_nxt = 1'b0;
    end else if (step.adv && step.prod) begin
      any_nxt = step.last ? 1'b0 : (any_r | (next_alive ^ centre));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      any_r    <= 1'b0;
    end else begin
      any_r <= any_nxt;
      if (step.adv) begin
        window_r <= window_nxt;
      end
    end
  end

  assign res.next_alive     = next_alive;
  assign res.changed_so_far = any_r | (next_alive ^ centre);

endmodule

@@ hdl/life_automaton_generation.sv @@
// ----------------------------------------------------------------------------
// life_automaton_generation
// One generation of a B3/S23 automaton over a raster cell stream.
// ----------------------------------------------------------------------------
// Cells of a square board with a dead border enter one per item in raster
// order, border included; the board side (3..MAX_SIDE, clamped) is set by a
// cfg_wen write, which also restarts the board. The block sustains one item
// per clock while the result side does not stall: an accepted item reads
// the two-row line buffer memory, and when it leaves the read stage the
// window, the rule and the write-back of that column run while the
// following item's read is issued. For each interior cell a result is
// registered when the item of its lower right neighbor leaves the read
// stage, carrying the next state, a flag that any cell of this board
// changed so far, and tlast on the board's final interior cell. Border
// positions give no result. The line buffers need no clearing: entries
// that were never written only reach the window on rows that give no result.
// ----------------------------------------------------------------------------
module life_automaton_generation
  import lag_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wen,
  input  logic [CFG_W-1:0] cfg_wdata,   // board_side
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // [0] cell_alive, [7:1] zero
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // [0] next_alive, [1] changed_so_far, [7:2] zero
  output logic             out_tlast    // last_interior
);

  localparam int AW       = $clog2(MAX_SIDE);
  localparam int SW       = ($clog2(MAX_SIDE + 1) > CFG_W) ? $clog2(MAX_SIDE + 1) : CFG_W;
  localparam int RST_SIDE = (MAX_SIDE < 1024) ? MAX_SIDE : 1024;

  // Raster position and side
  logic [AW-1:0] side_last_r, side_last_nxt;
  logic [AW-1:0] row_r, row_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [SW-1:0] side_wide;

  // Read stage
  logic          s1_v_r, s1_v_nxt;
  logic          s1_cell_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_prod_r;
  logic          s1_last_r;
  logic          s1_adv;
  logic          in_accept;

  // Output register
  logic          out_v_r, out_v_nxt;
  logic          out_alive_r;
  logic          out_changed_r;
  logic          out_last_r;

  logic [1:0]    rd_data;
  lag_step_t     step;
  lag_res_t      res;

  // Handshake
  assign s1_adv    = s1_v_r && (!s1_prod_r || !out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Clamp the written side and keep side-1
  always_comb begin
    side_wide = SW'(cfg_wdata);
    if (side_wide < SW'(MIN_SIDE)) begin
      side_last_nxt = AW'(MIN_SIDE - 1);
    end else if (side_wide > SW'(MAX_SIDE)) begin
      side_last_nxt = AW'(MAX_SIDE - 1);
    end else begin
      side_last_nxt = AW'(side_wide - SW'(1));
    end
  end

  // Raster counters
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wen) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_accept) begin
      if (col_r == side_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == side_last_r) ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_last_r <= AW'(RST_SIDE - 1);
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (cfg_wen) begin
        side_last_r <= side_last_nxt;
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Read stage register
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell_r <= in_tdata[0];
      s1_col_r  <= col_r;
      s1_prod_r <= (row_r >= AW'(2)) && (col_r >= AW'(2));
      s1_last_r <= (row_r == side_last_r) && (col_r == side_last_r);
    end
  end

  // Line buffers: upper takes the old middle, middle takes the new cell
  lag_line_mem #(
    .DEPTH (MAX_SIDE)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ({s1_cell_r, rd_data[1]})
  );

  // Window and rule
  always_comb begin
    step.adv     = s1_adv;
    step.restart = cfg_wen;
    step.cell_in = s1_cell_r;
    step.up      = rd_data[0];
    step.mid     = rd_data[1];
    step.prod    = s1_prod_r;
    step.last    = s1_last_r;
  end

  lag_rule u_rule (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  // Output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv && s1_prod_r) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_prod_r) begin
      out_alive_r   <= res.next_alive;
      out_changed_r <= res.changed_so_far;
      out_last_r    <= s1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, out_changed_r, out_alive_r};
  assign out_tlast  = out_last_r;

  // Raster position never passes the board edge
  a_pos_in_board: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= side_last_r) && (col_r <= side_last_r))
    else $error("raster position beyond board side");

  // A result-carrying item waits in the read stage while the output stalls
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_prod_r && out_v_r && !out_tready) |=> s1_v_r)
    else $error("stalled item lost from read stage");

  // An accepted item always lands in the read stage
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_v_r)
    else $error("accepted item not in read stage");

endmodule

@@ tb/sv/life_automaton_generation_tb.sv @@
// ----------------------------------------------------------------------------
// life_automaton_generation_tb
// Self-checking bench for one B3/S23 generation over a raster cell stream.
// ----------------------------------------------------------------------------
// Boards are streamed cell by cell, border included. A local predictor keeps
// its own line buffers, window, raster position and change flag. It queues the
// next state, the running change flag and the last-interior mark for every
// accepted interior cell. Results are checked in order against that queue.
// The run covers the reset side, clamped sides at both ends, small
// hand-built boards and random boards under several idling mixes. One
// stretch holds off the result side long enough to stall the input.
// ----------------------------------------------------------------------------
module life_automaton_generation_tb;
  import lag_pkg::*;

  localparam int MAX_SIDE = 1024;

  typedef struct packed {
    logic next_alive;
    logic changed_so_far;
    logic last_interior;
  } cell_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_wen    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             out_tlast;

  // idling knobs and hold-off request
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int mismatch_count = 0;

  cell_result_t expected_cells[$];
  cell_result_t head_result;

  // predictor state
  logic             upper_buf  [MAX_SIDE];
  logic             middle_buf [MAX_SIDE];
  logic [8:0]       win_bits      = '0;
  int unsigned      row_pos       = 0;
  int unsigned      col_pos       = 0;
  logic             board_changed = 1'b0;
  logic [CFG_W-1:0] side_reg      = 11'd1024;

  life_automaton_generation #(
    .MAX_SIDE(MAX_SIDE)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls, plus a counted hold-off on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // compare each result item with the oldest queued prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("result with none pending, tdata %h tlast %b",
                                  out_tdata, out_tlast));
      end else begin
        head_result = expected_cells.pop_front();
        if (out_tdata[0] !== head_result.next_alive)
          report_mismatch($sformatf("next_alive %b, want %b",
                                    out_tdata[0], head_result.next_alive));
        if (out_tdata[1] !== head_result.changed_so_far)
          report_mismatch($sformatf("changed_so_far %b, want %b",
                                    out_tdata[1], head_result.changed_so_far));
        if (out_tlast !== head_result.last_interior)
          report_mismatch($sformatf("last_interior %b, want %b",
                                    out_tlast, head_result.last_interior));
      end
    end
  end

  // one accepted cell: advance the predictor and queue any result
  task automatic predict_generation_step(input logic alive);
    int unsigned  s;
    int unsigned  ci;
    int           score;
    logic         up_bit;
    logic         mid_bit;
    logic         centre;
    logic         nxt;
    cell_result_t res;
    s = side_reg;
    if (s < MIN_SIDE) s = MIN_SIDE;
    if (s > MAX_SIDE) s = MAX_SIDE;
    ci = col_pos % MAX_SIDE;
    up_bit = upper_buf[ci];
    mid_bit = middle_buf[ci];
    // shift the window one column; newest column is bits 2, 5, 8
    win_bits = ((win_bits >> 1) & 9'h0DB) | {alive, 2'b00, mid_bit, 2'b00, up_bit, 2'b00};
    upper_buf[ci] = mid_bit;
    middle_buf[ci] = alive;
    if (row_pos >= 2 && col_pos >= 2 && row_pos < s && col_pos < s) begin
      centre = win_bits[4];
      score = $countones(win_bits & 9'h1EF);
      nxt = (score == BIRTH_COUNT) || (centre && score == SURVIVE_COUNT);
      board_changed = board_changed | (nxt ^ centre);
      res.next_alive = nxt;
      res.changed_so_far = board_changed;
      res.last_interior = (row_pos == s - 1) && (col_pos == s - 1);
      expected_cells.push_back(res);
    end
    // raster position, wrapping at the board's end
    if (col_pos >= s - 1) begin
      col_pos = 0;
      if (row_pos >= s - 1) begin
        row_pos = 0;
        board_changed = 1'b0;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // offer one cell item, with a random gap ahead of it
  task automatic push_cell(input logic alive);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, alive};
    do @(posedge clk); while (!in_tready);
    predict_generation_step(alive);
  endtask

  // cells in raster order from the low bit up
  task automatic push_pattern(input logic [63:0] cells, input int count);
    for (int i = 0; i < count; i++) push_cell(cells[i]);
  endtask

  task automatic push_random_cells(input int count, input int alive_pct);
    for (int i = 0; i < count; i++) push_cell($urandom_range(99) < alive_pct);
  endtask

  // side write once the block has drained; restarts the board
  task automatic write_side(input logic [CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    side_reg = value;
    row_pos = 0;
    col_pos = 0;
    board_changed = 1'b0;
  endtask

  // reset side of 1024: part of the first border row, no result expected
  task automatic test_reset_side();
    send_idle_pct = 37;
    recv_stall_pct = 37;
    push_random_cells(30, 50);
  endtask

  // sides below the minimum clamp to 3: one interior cell per board
  task automatic test_min_side();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_side(11'd0);
    push_pattern(64'h1FF, 9);   // crowded centre dies
    write_side(11'd1);
    push_pattern(64'h015, 9);   // centre with two neighbors survives
    write_side(11'd2);
    push_pattern(64'h007, 9);   // dead centre with three neighbors is born
    write_side(11'd3);
    push_pattern(64'h000, 9);   // empty board stays empty
  endtask

  // 2x2 block is a still life: no change flag on any result
  task automatic test_still_life();
    send_idle_pct = 61;
    recv_stall_pct = 0;
    write_side(11'd4);
    push_pattern(64'h0660, 16);
    push_pattern(64'h0660, 16);
  endtask

  // all-ones side clamps to the maximum: first border row gives no result
  task automatic test_max_side();
    send_idle_pct = 0;
    recv_stall_pct = 61;
    write_side(11'h7FF);
    push_random_cells(30, 50);
  endtask

  // whole random boards, now and then a cut-off board before the next side
  task automatic test_random_boards(input int send_pct, input int recv_pct,
                                    input int goal);
    int sent;
    int side_val;
    int s;
    int boards;
    int pct;
    int part;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < goal) begin
      if ($urandom_range(9) == 0) side_val = $urandom_range(2);
      else side_val = $urandom_range(3, 9);
      s = (side_val < MIN_SIDE) ? MIN_SIDE : side_val;
      write_side(side_val[CFG_W-1:0]);
      boards = $urandom_range(1, 3);
      for (int b = 0; b < boards; b++) begin
        case ($urandom_range(5))
          0:       pct = 0;
          1:       pct = 100;
          default: pct = $urandom_range(15, 60);
        endcase
        push_random_cells(s * s, pct);
        sent += s * s;
      end
      if ($urandom_range(4) == 0) begin
        part = $urandom_range(1, s * s - 1);
        push_random_cells(part, 40);
        sent += part;
      end
    end
  endtask

  // long result hold-off while the input keeps streaming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_side(11'd5);
    hold_request = 300;
    push_random_cells(60, 45);
  endtask

  initial begin
    foreach (upper_buf[i]) begin
      upper_buf[i] = 1'b0;
      middle_buf[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_side();
    test_min_side();
    test_still_life();
    test_max_side();
    test_random_boards(0, 0, 60);
    test_random_boards(61, 0, 60);
    test_random_boards(0, 61, 60);
    test_random_boards(37, 37, 60);
    test_backpressure();

    // drain, then a short quiet tail
    in_tvalid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
